// File: sv/drm_pkg.sv
// shared types, constants and rectangle functions for the dirty rectangle merger
// no dependencies
package drm_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int BOX_W = 64;

  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_FLUSH,
    MODE_REPLACE
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_APPEND,
    ST_REPLACE,
    ST_EMPTY,
    ST_M_START,
    ST_M_RDI,
    ST_M_LDI,
    ST_M_RDJ,
    ST_M_CMP,
    ST_SH_CHK,
    ST_SH_WR,
    ST_E_RD,
    ST_E_OUT
  } state_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
  } box_t;

  function automatic logic box_empty(box_t b);
    return (b.w == 16'd0) || (b.h == 16'd0);
  endfunction

  function automatic logic signed [17:0] ext_u(logic [15:0] v);
    return $signed({2'b00, v});
  endfunction

  function automatic logic box_overlap(box_t a, box_t b);
    logic signed [17:0] ax, ay, bx, by;
    logic ov;
    ax = 18'(a.x);
    ay = 18'(a.y);
    bx = 18'(b.x);
    by = 18'(b.y);
    ov = 1'b1;
    if (box_empty(a) || box_empty(b)) ov = 1'b0;
    if (bx + ext_u(b.w) <= ax) ov = 1'b0;
    if (bx >= ax + ext_u(a.w)) ov = 1'b0;
    if (by - ext_u(b.h) >= ay) ov = 1'b0;
    if (by <= ay - ext_u(a.h)) ov = 1'b0;
    return ov;
  endfunction

  function automatic logic [15:0] sat16(logic signed [17:0] v);
    return (v > 18'sd65535) ? 16'hFFFF : v[15:0];
  endfunction

  // bounding box of a and b, a is the target
  function automatic box_t box_union(box_t a, box_t b);
    logic signed [17:0] ax, ay, bx, by, lft, rgt, top, bot, ar, br, ab, bb;
    box_t u;
    ax = 18'(a.x);
    ay = 18'(a.y);
    bx = 18'(b.x);
    by = 18'(b.y);
    ar = ax + ext_u(a.w);
    br = bx + ext_u(b.w);
    ab = ay - ext_u(a.h);
    bb = by - ext_u(b.h);
    lft = (ax < bx) ? ax : bx;
    rgt = (br > ar) ? br : ar;
    top = (ay > by) ? ay : by;
    bot = (bb < ab) ? bb : ab;
    u = a;
    if (box_empty(b)) begin
      u = a;
    end else if (box_empty(a)) begin
      u = b;
    end else begin
      u.x = lft[15:0];
      u.y = top[15:0];
      u.w = sat16(rgt - lft);
      u.h = sat16(top - bot);
    end
    return u;
  endfunction

endpackage

// File: sv/drm_if.sv
// request and result channel interfaces of the dirty rectangle merger
// no dependencies
interface drm_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic [14:0]        rect_width;
  logic [14:0]        rect_height;

  modport source (output valid, mode, rect_x, rect_y, rect_width, rect_height,
                  input ready);
  modport sink (input valid, mode, rect_x, rect_y, rect_width, rect_height,
                output ready);
endinterface

interface drm_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic [15:0]        out_width;
  logic [15:0]        out_height;
  logic               list_empty;
  logic               last_item;
  logic               overflowed;

  modport source (output valid, out_x, out_y, out_width, out_height, list_empty,
                  last_item, overflowed, input ready);
  modport sink (input valid, out_x, out_y, out_width, out_height, list_empty,
                last_item, overflowed, output ready);
endinterface

// File: sv/drm_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module drm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/dirty_rect_merger.sv
// dirty rectangle merger top level: sequencer around the rectangle table ram
// depends on drm_pkg, drm_if (drm_cmd_if, drm_result_if) and drm_ram
//
//  channel  | dir | contents
//  ---------+-----+------------------------------------------------------
//  cmd      | in  | mode, rect_x, rect_y, rect_width, rect_height
//  result   | out | out_x, out_y, out_width, out_height, list_empty,
//           |     | last_item, overflowed (flush only)
//
// one request at a time; each table access is a ram read then a compare/union and
// an optional write back. add scans the entries and merges into the first overlap,
// else appends, or folds into the last entry when full; replace writes entry 0.
// empty flush emits one empty result; flush per pass: start, a read and load per row,
// a read and compare per pair, a shift of later entries on a removal; then a read and
// output per entry, stalled by a full result. reset clears state, count, ovf, valid.
module dirty_rect_merger
  import drm_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic         clk,
  input logic         rst,
  drm_cmd_if.sink     cmd,
  drm_result_if.source result
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic ovf, ovf_next;
  logic [CW-1:0] i, i_next, j, j_next, k, k_next;
  box_t nb, nb_next, a, a_next;
  logic o_valid, o_valid_next;
  box_t o_box, o_box_next;
  logic o_empty, o_empty_next, o_last, o_last_next, o_ovf, o_ovf_next;

  logic we;
  logic [IW-1:0] waddr, raddr;
  box_t wbox, rbox;
  logic [BOX_W-1:0] rdata;
  logic slot_free;
  box_t cmd_box;

  drm_ram #(.WIDTH(BOX_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wbox),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rbox = box_t'(rdata);
  assign slot_free = !o_valid || result.ready;
  assign cmd.ready = (state == ST_IDLE);

  always_comb begin
    cmd_box.x = cmd.rect_x;
    cmd_box.y = cmd.rect_y;
    cmd_box.w = {1'b0, cmd.rect_width};
    cmd_box.h = {1'b0, cmd.rect_height};
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next = ovf;
    i_next = i;
    j_next = j;
    k_next = k;
    nb_next = nb;
    a_next = a;
    o_valid_next = o_valid && !result.ready;
    o_box_next = o_box;
    o_empty_next = o_empty;
    o_last_next = o_last;
    o_ovf_next = o_ovf;
    we = 1'b0;
    waddr = '0;
    wbox = nb;
    raddr = '0;

    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          nb_next = cmd_box;
          i_next = '0;
          case (mode_t'(cmd.mode))
            MODE_ADD:     state_next = (count == '0) ? ST_APPEND : ST_ADD_RD;
            MODE_FLUSH:   state_next = (count == '0) ? ST_EMPTY : ST_M_START;
            MODE_REPLACE: state_next = ST_REPLACE;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD: begin
        raddr = i[IW-1:0];
        state_next = ST_ADD_CMP;
      end
      ST_ADD_CMP: begin
        if (box_overlap(rbox, nb)) begin
          we = 1'b1;
          waddr = i[IW-1:0];
          wbox = box_union(rbox, nb);
          state_next = ST_IDLE;
        end else if (i + ONE == count) begin
          if (count < CAP) begin
            state_next = ST_APPEND;
          end else begin
            // table full: fold into the last entry, which was just read
            we = 1'b1;
            waddr = i[IW-1:0];
            wbox = box_union(rbox, nb);
            ovf_next = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          i_next = i + ONE;
          state_next = ST_ADD_RD;
        end
      end
      ST_APPEND: begin
        we = 1'b1;
        waddr = count[IW-1:0];
        count_next = count + ONE;
        state_next = ST_IDLE;
      end
      ST_REPLACE: begin
        we = 1'b1;
        waddr = '0;
        count_next = ONE;
        state_next = ST_IDLE;
      end
      ST_EMPTY: begin
        if (slot_free) begin
          o_valid_next = 1'b1;
          o_box_next = '0;
          o_empty_next = 1'b1;
          o_last_next = 1'b1;
          o_ovf_next = ovf;
          ovf_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      ST_M_START: begin
        i_next = '0;
        k_next = '0;
        state_next = (count < CW'(2)) ? ST_E_RD : ST_M_RDI;
      end
      ST_M_RDI: begin
        raddr = i[IW-1:0];
        state_next = ST_M_LDI;
      end
      ST_M_LDI: begin
        a_next = rbox;
        j_next = i + ONE;
        state_next = ST_M_RDJ;
      end
      ST_M_RDJ: begin
        raddr = j[IW-1:0];
        state_next = ST_M_CMP;
      end
      ST_M_CMP: begin
        if (box_overlap(a, rbox)) begin
          we = 1'b1;
          waddr = i[IW-1:0];
          wbox = box_union(a, rbox);
          k_next = j + ONE;
          state_next = ST_SH_CHK;
        end else if (j + ONE == count) begin
          i_next = i + ONE;
          k_next = '0;
          // no pair left once the next row has no partner
          state_next = (i + CW'(2) >= count) ? ST_E_RD : ST_M_RDI;
        end else begin
          j_next = j + ONE;
          state_next = ST_M_RDJ;
        end
      end
      ST_SH_CHK: begin
        if (k < count) begin
          raddr = k[IW-1:0];
          state_next = ST_SH_WR;
        end else begin
          count_next = count - ONE;
          state_next = ST_M_START;
        end
      end
      ST_SH_WR: begin
        we = 1'b1;
        waddr = IW'(k - ONE);
        wbox = rbox;
        k_next = k + ONE;
        state_next = ST_SH_CHK;
      end
      ST_E_RD: begin
        raddr = k[IW-1:0];
        state_next = ST_E_OUT;
      end
      ST_E_OUT: begin
        // keep the address so read data holds while the result slot is busy
        raddr = k[IW-1:0];
        if (slot_free) begin
          o_valid_next = 1'b1;
          o_box_next = rbox;
          o_empty_next = 1'b0;
          o_last_next = (k + ONE == count);
          o_ovf_next = ovf;
          if (k + ONE == count) begin
            count_next = '0;
            ovf_next = 1'b0;
            state_next = ST_IDLE;
          end else begin
            k_next = k + ONE;
            state_next = ST_E_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      ovf <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf <= ovf_next;
      o_valid <= o_valid_next;
    end
    i <= i_next;
    j <= j_next;
    k <= k_next;
    nb <= nb_next;
    a <= a_next;
    o_box <= o_box_next;
    o_empty <= o_empty_next;
    o_last <= o_last_next;
    o_ovf <= o_ovf_next;
  end

  assign result.valid = o_valid;
  assign result.out_x = o_box.x;
  assign result.out_y = o_box.y;
  assign result.out_width = o_box.w;
  assign result.out_height = o_box.h;
  assign result.list_empty = o_empty;
  assign result.last_item = o_last;
  assign result.overflowed = o_ovf;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("entry count above capacity");
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_M_CMP |-> (i < j) && (j < count))
    else $error("merge pair out of order");
  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    state == ST_E_OUT |-> k < count)
    else $error("emit index past table end");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.list_empty |-> result.last_item && result.out_width == 16'd0)
    else $error("empty flush result malformed");
`endif

endmodule

// File: tb/tb_dirty_rect_merger.sv
// testbench for dirty_rect_merger: directed and random requests checked against
// a behavioral table model; depends on drm_pkg, drm_if and the merger rtl
module tb_dirty_rect_merger;
  import drm_pkg::*;

  localparam int CAP = 16;
  localparam int QUIET_LIMIT = 40000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    int          x;
    int          y;
    int unsigned w;
    int unsigned h;
  } rect_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic               empty;
    logic               last;
    logic               ovf;
  } flush_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  drm_cmd_if    cmd();
  drm_result_if res();

  dirty_rect_merger DUT (.clk(clk), .rst(rst), .cmd(cmd), .result(res));

  always #5 clk = ~clk;

  rect_t       table_q[CAP];
  int unsigned table_cnt;
  bit          table_ovf;
  flush_res_t  expected_q[$];

  int errors;
  int idle_pct;
  int stall_pct;
  int hold_left;
  int quiet_cycles;
  int sent;

  function automatic bit rect_empty(rect_t r);
    return r.w == 0 || r.h == 0;
  endfunction

  function automatic bit rect_overlap(rect_t a, rect_t b);
    if (rect_empty(a) || rect_empty(b)) return 0;
    if (b.x + int'(b.w) <= a.x) return 0;
    if (b.x >= a.x + int'(a.w)) return 0;
    if (b.y - int'(b.h) >= a.y) return 0;
    if (b.y <= a.y - int'(a.h)) return 0;
    return 1;
  endfunction

  function automatic int unsigned clip16(int v);
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic rect_t bounding_box(rect_t a, rect_t b);
    rect_t u;
    int lft, rgt, top, bot;
    if (rect_empty(b)) return a;
    if (rect_empty(a)) return b;
    lft = (a.x < b.x) ? a.x : b.x;
    rgt = a.x + int'(a.w);
    if (b.x + int'(b.w) > rgt) rgt = b.x + int'(b.w);
    top = (a.y > b.y) ? a.y : b.y;
    bot = a.y - int'(a.h);
    if (b.y - int'(b.h) < bot) bot = b.y - int'(b.h);
    u.x = lft;
    u.y = top;
    u.w = clip16(rgt - lft);
    u.h = clip16(top - bot);
    return u;
  endfunction

  function automatic flush_res_t make_res(rect_t r, bit e, bit l);
    flush_res_t f;
    f.x = r.x[15:0];
    f.y = r.y[15:0];
    f.w = r.w[15:0];
    f.h = r.h[15:0];
    f.empty = e;
    f.last = l;
    f.ovf = table_ovf;
    return f;
  endfunction

  // collapse overlapping pairs until none is left, first pair first
  task automatic collapse_table();
    bit again;
    bit hit;
    again = 1;
    while (again) begin
      again = 0;
      for (int i = 0; i < int'(table_cnt) && !again; i++) begin
        for (int j = i + 1; j < int'(table_cnt) && !again; j++) begin
          if (rect_overlap(table_q[i], table_q[j])) begin
            table_q[i] = bounding_box(table_q[i], table_q[j]);
            for (int k = j; k < int'(table_cnt) - 1; k++) table_q[k] = table_q[k + 1];
            table_cnt--;
            again = 1;
          end
        end
      end
    end
  endtask

  task automatic apply_request(logic [1:0] m, rect_t nb);
    bit done;
    rect_t z;
    done = 0;
    z = '{0, 0, 0, 0};
    case (m)
      MODE_ADD: begin
        for (int i = 0; i < int'(table_cnt) && !done; i++) begin
          if (rect_overlap(table_q[i], nb)) begin
            table_q[i] = bounding_box(table_q[i], nb);
            done = 1;
          end
        end
        if (!done) begin
          if (table_cnt < CAP) begin
            table_q[table_cnt] = nb;
            table_cnt++;
          end else begin
            table_q[CAP - 1] = bounding_box(table_q[CAP - 1], nb);
            table_ovf = 1;
          end
        end
      end
      MODE_REPLACE: begin
        table_q[0] = nb;
        table_cnt = 1;
      end
      MODE_FLUSH: begin
        if (table_cnt == 0) begin
          expected_q.push_back(make_res(z, 1, 1));
        end else begin
          collapse_table();
          for (int i = 0; i < int'(table_cnt); i++)
            expected_q.push_back(make_res(table_q[i], 0, i + 1 == int'(table_cnt)));
        end
        table_cnt = 0;
        table_ovf = 0;
      end
      default: ;
    endcase
  endtask

  // drive one request from a falling edge and wait for it to be taken
  task automatic send_rect(logic [1:0] m, logic signed [15:0] x, logic signed [15:0] y,
                           logic [14:0] w, logic [14:0] h);
    rect_t nb;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      cmd.valid = 1'b0;
      @(negedge clk);
    end
    cmd.valid = 1'b1;
    cmd.mode = m;
    cmd.rect_x = x;
    cmd.rect_y = y;
    cmd.rect_width = w;
    cmd.rect_height = h;
    do @(posedge clk); while (!cmd.ready);
    nb.x = x;
    nb.y = y;
    nb.w = w;
    nb.h = h;
    apply_request(m, nb);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    cmd.valid = 1'b0;
    wait (expected_q.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      res.ready = 1'b0;
      hold_left--;
    end else begin
      res.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    flush_res_t e;
    if (!rst && res.valid && res.ready) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (res.out_x !== e.x) report_mismatch("out_x", res.out_x, e.x);
        if (res.out_y !== e.y) report_mismatch("out_y", res.out_y, e.y);
        if (res.out_width !== e.w) report_mismatch("out_width", res.out_width, e.w);
        if (res.out_height !== e.h) report_mismatch("out_height", res.out_height, e.h);
        if (res.list_empty !== e.empty) report_mismatch("list_empty", res.list_empty, e.empty);
        if (res.last_item !== e.last) report_mismatch("last_item", res.last_item, e.last);
        if (res.overflowed !== e.ovf) report_mismatch("overflowed", res.overflowed, e.ovf);
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || rst) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_empty_and_unused();
    send_rect(MODE_FLUSH, 0, 0, 0, 0);
    send_rect(MODE_UNUSED, 16'sh7FFF, -16'sd1, 15'h7FFF, 15'h7FFF);
    send_rect(MODE_FLUSH, -16'sd1, 16'sh7FFF, 15'h7FFF, 15'h7FFF);
    drain();
  endtask

  task automatic test_extremes_and_empties();
    send_rect(MODE_ADD, -16'sd32768, 16'sh7FFF, 15'h7FFF, 15'h7FFF);
    send_rect(MODE_ADD, -16'sd100, 16'sd100, 15'h7FFF, 15'h7FFF);
    send_rect(MODE_ADD, 16'sd5, 16'sd5, 15'd0, 15'd9);
    send_rect(MODE_ADD, 16'sd5, 16'sd5, 15'd9, 15'd0);
    send_rect(MODE_ADD, 16'sh7FFF, -16'sd32768, 15'd1, 15'd1);
    send_rect(MODE_FLUSH, 0, 0, 0, 0);
    // empty entry overlaps nothing, so the next rectangle is appended after it
    send_rect(MODE_REPLACE, 16'sd3, 16'sd3, 15'd0, 15'd0);
    send_rect(MODE_ADD, 16'sd3, 16'sd3, 15'd4, 15'd4);
    send_rect(MODE_FLUSH, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < CAP; i++)
      send_rect(MODE_ADD, -16'sd32000 + 16'(i * 1000), 16'sd0, 15'd10, 15'd10);
    // disjoint, far away: widens the last entry past 16 bits, so its width saturates
    send_rect(MODE_ADD, 16'sh7FFF, 16'sd0, 15'h7FFF, 15'd5);
    send_rect(MODE_ADD, -16'sd32768, 16'sh7FFF, 15'd1, 15'd1);
    send_rect(MODE_REPLACE, 16'sd1, 16'sd1, 15'd2, 15'd2);
    send_rect(MODE_FLUSH, 0, 0, 0, 0);
    send_rect(MODE_FLUSH, 0, 0, 0, 0);
    drain();
  endtask

  task automatic random_item(int wide);
    int m;
    m = $urandom_range(99);
    if (wide)
      send_rect(m < 90 ? MODE_ADD : MODE_REPLACE, 16'($urandom), 16'($urandom),
                15'($urandom), 15'($urandom));
    else if (m < 4)
      send_rect(MODE_UNUSED, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
    else
      send_rect(m < 12 ? MODE_REPLACE : MODE_ADD,
                16'($urandom_range(300)) - 16'sd150, 16'($urandom_range(300)) - 16'sd150,
                15'($urandom_range(m < 20 ? 0 : 1, 80)), 15'($urandom_range(m < 20 ? 0 : 1, 80)));
  endtask

  task automatic test_random_bursts(int n);
    int stop;
    stop = sent + n;
    while (sent < stop) begin
      repeat ($urandom_range(1, 22)) random_item($urandom_range(9) == 0);
      send_rect(MODE_FLUSH, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_left = 600;
    for (int k = 0; k < 4; k++) begin
      repeat (CAP) send_rect(MODE_ADD, 16'($urandom_range(4000)) - 16'sd2000,
                             16'($urandom_range(4000)) - 16'sd2000, 15'd20, 15'd20);
      send_rect(MODE_FLUSH, 0, 0, 0, 0);
    end
    drain();
  endtask

  initial begin
    errors = 0;
    sent = 0;
    hold_left = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    table_cnt = 0;
    table_ovf = 0;
    cmd.valid = 1'b0;
    cmd.mode = MODE_ADD;
    cmd.rect_x = '0;
    cmd.rect_y = '0;
    cmd.rect_width = '0;
    cmd.rect_height = '0;
    res.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_and_unused();
    test_extremes_and_empties();
    test_overflow();
    test_random_bursts(25);
    idle_pct = 86;
    test_random_bursts(20);
    idle_pct = 0;
    stall_pct = 86;
    test_random_bursts(20);
    idle_pct = 35;
    stall_pct = 35;
    test_random_bursts(20);
    idle_pct = 0;
    stall_pct = 0;
    test_backpressure();
    test_random_bursts(15);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
